// ===== rtl/blp_pkg.sv =====
// ----------------------------------------------------------------------------
// blp_pkg: shared types and constants of the debounced button lock panel
// Widths, event and command codes, the queue entry type and the lamp color
// table used by the front, the queue and the back.
// ----------------------------------------------------------------------------
package blp_pkg;

    localparam int BUTTONS         = 6;
    localparam int PIXELS_PER_LAMP = 2;
    localparam int LEVEL_W         = 6;
    localparam int AGE_W           = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int LAMP_W          = 8;
    localparam int COLOR_CODE_W    = 3;
    localparam int KIND_W          = 2;
    localparam int BTN_NUM_W       = 3;
    localparam int PIXEL_W         = 4;
    localparam int COLOR_W         = 24;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [CFG_W-1:0] HEARTBEAT_RESET = 16'd10000;

    // Command codes of an input transfer.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LAMP = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd1;

    // Event kinds of a result transfer.
    localparam logic [KIND_W-1:0] EVT_PRESS     = 2'd0;
    localparam logic [KIND_W-1:0] EVT_HEARTBEAT = 2'd1;
    localparam logic [KIND_W-1:0] EVT_LAMP      = 2'd2;

    // Lamp color codes.
    localparam logic [COLOR_CODE_W-1:0] COLOR_RED    = 3'd1;
    localparam logic [COLOR_CODE_W-1:0] COLOR_GREEN  = 3'd2;
    localparam logic [COLOR_CODE_W-1:0] COLOR_BLUE   = 3'd3;
    localparam logic [COLOR_CODE_W-1:0] COLOR_YELLOW = 3'd4;

    localparam logic [7:0] FULL_ON = 8'd255;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] heartbeat_ticks;
    } cfg_t;

    // One queue entry: every result that a single input transfer causes.
    typedef struct packed {
        logic [BUTTONS-1:0] press;
        logic               heartbeat;
        logic               lamp;
        logic [PIXEL_W-1:0] first_pixel;
        logic [COLOR_W-1:0] pixel_color;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [COLOR_W-1:0] color_of(input logic [COLOR_CODE_W-1:0] code);
        logic [COLOR_W-1:0] c;
        c = '0;
        unique case (code)
            COLOR_RED:    c = {FULL_ON, 8'd0, 8'd0};
            COLOR_GREEN:  c = {8'd0, FULL_ON, 8'd0};
            COLOR_BLUE:   c = {8'd0, 8'd0, FULL_ON};
            COLOR_YELLOW: c = {FULL_ON, FULL_ON, 8'd0};
            default:      c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/blp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// blp_cmd_if: input channel of the button lock panel
// Valid/ready channel carrying one tick sample or one lamp command.
// ----------------------------------------------------------------------------
interface blp_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [blp_pkg::LEVEL_W-1:0]         button_levels;
    logic                                for_this_unit;
    logic [blp_pkg::LAMP_W-1:0]          lamp_number;
    logic [blp_pkg::COLOR_CODE_W-1:0]    color_code;

    modport source (
        output valid, command, button_levels, for_this_unit, lamp_number, color_code,
        input  ready
    );

    modport sink (
        input  valid, command, button_levels, for_this_unit, lamp_number, color_code,
        output ready
    );
endinterface

// ===== rtl/blp_evt_if.sv =====
// ----------------------------------------------------------------------------
// blp_evt_if: result channel of the button lock panel
// Valid/ready channel carrying one press, heartbeat or lamp write event.
// ----------------------------------------------------------------------------
interface blp_evt_if;
    logic                              valid;
    logic                              ready;
    logic [blp_pkg::KIND_W-1:0]        event_kind;
    logic [blp_pkg::BTN_NUM_W-1:0]     button_number;
    logic [blp_pkg::PIXEL_W-1:0]       first_pixel;
    logic [blp_pkg::COLOR_W-1:0]       pixel_color;
    logic                              last_of_run;

    modport source (
        output valid, event_kind, button_number, first_pixel, pixel_color, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, event_kind, button_number, first_pixel, pixel_color, last_of_run,
        output ready
    );
endinterface

// ===== rtl/blp_front.sv =====
// ----------------------------------------------------------------------------
// blp_front: debounce and lock front end
// Accepts input transfers, updates the per-button debounce state, the locks
// and the heartbeat age, and pushes one run entry per item that has results.
// ----------------------------------------------------------------------------
module blp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  blp_pkg::cfg_t          cfg,
    blp_cmd_if.sink                cmd,
    input  blp_pkg::queue_status_t qstat,
    output logic                   push,
    output blp_pkg::run_t          push_run
);

    logic [blp_pkg::BUTTONS-1:0] raw_prev_reg,  raw_prev_next;
    logic [blp_pkg::BUTTONS-1:0] stable_reg,    stable_next;
    logic [blp_pkg::BUTTONS-1:0] locked_reg,    locked_next;
    logic [blp_pkg::AGE_W-1:0]   age_reg  [blp_pkg::BUTTONS];
    logic [blp_pkg::AGE_W-1:0]   age_next [blp_pkg::BUTTONS];
    logic [blp_pkg::AGE_W-1:0]   hb_age_reg, hb_age_next;

    logic                        accept;
    logic [blp_pkg::BUTTONS-1:0] press;
    logic                        heartbeat;
    logic                        lamp_hit;
    logic [blp_pkg::AGE_W-1:0]   hb_inc;
    logic [blp_pkg::LAMP_W-1:0]  lamp_idx;

    assign cmd.ready = !qstat.full;
    assign accept    = cmd.valid && cmd.ready;
    assign lamp_idx  = cmd.lamp_number - blp_pkg::LAMP_W'(1);

    always_comb
    begin
        raw_prev_next = raw_prev_reg;
        stable_next   = stable_reg;
        locked_next   = locked_reg;
        hb_age_next   = hb_age_reg;
        press         = '0;
        heartbeat     = 1'b0;
        lamp_hit      = 1'b0;
        hb_inc        = '0;
        for (int i = 0; i < blp_pkg::BUTTONS; i++)
        begin
            age_next[i] = age_reg[i];
        end

        if (cmd.command == blp_pkg::CMD_TICK)
        begin
            // Each button is an independent lane.
            for (int i = 0; i < blp_pkg::BUTTONS; i++)
            begin
                if (cmd.button_levels[i] != raw_prev_reg[i])
                begin
                    age_next[i] = '0;
                end
                else if (age_reg[i] != blp_pkg::AGE_MAX)
                begin
                    age_next[i] = age_reg[i] + blp_pkg::AGE_W'(1);
                end
                if (age_next[i] > cfg.debounce_ticks && cmd.button_levels[i] != stable_reg[i])
                begin
                    stable_next[i] = cmd.button_levels[i];
                    if (!cmd.button_levels[i] && !locked_reg[i])
                    begin
                        press[i]       = 1'b1;
                        locked_next[i] = 1'b1;
                    end
                end
                raw_prev_next[i] = cmd.button_levels[i];
            end

            hb_inc = (hb_age_reg != blp_pkg::AGE_MAX) ? hb_age_reg + blp_pkg::AGE_W'(1)
                                                       : hb_age_reg;
            if (hb_inc > cfg.heartbeat_ticks)
            begin
                hb_age_next = '0;
                heartbeat   = 1'b1;
            end
            else
            begin
                hb_age_next = hb_inc;
            end
        end
        else
        begin
            if (cmd.for_this_unit && cmd.lamp_number >= blp_pkg::LAMP_W'(1)
                && cmd.lamp_number <= blp_pkg::LAMP_W'(blp_pkg::BUTTONS))
            begin
                lamp_hit = 1'b1;
                for (int i = 0; i < blp_pkg::BUTTONS; i++)
                begin
                    if (lamp_idx == blp_pkg::LAMP_W'(i))
                    begin
                        locked_next[i] = 1'b0;
                    end
                end
            end
        end
    end

    assign push_run.press       = press;
    assign push_run.heartbeat   = heartbeat;
    assign push_run.lamp        = lamp_hit;
    assign push_run.first_pixel = blp_pkg::PIXEL_W'(lamp_idx * blp_pkg::PIXELS_PER_LAMP);
    assign push_run.pixel_color = blp_pkg::color_of(cmd.color_code);
    assign push                 = accept && ((|press) || heartbeat || lamp_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= '1;
            stable_reg   <= '1;
            locked_reg   <= '0;
            hb_age_reg   <= '0;
            for (int i = 0; i < blp_pkg::BUTTONS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            raw_prev_reg <= raw_prev_next;
            stable_reg   <= stable_next;
            locked_reg   <= locked_next;
            hb_age_reg   <= hb_age_next;
            for (int i = 0; i < blp_pkg::BUTTONS; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

endmodule

// ===== rtl/blp_queue.sv =====
// ----------------------------------------------------------------------------
// blp_queue: run entry queue
// Short first-in first-out queue of run entries between front and back.
// ----------------------------------------------------------------------------
module blp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  blp_pkg::run_t          push_run,
    input  logic                   pop,
    output blp_pkg::run_t          pop_run,
    output blp_pkg::queue_status_t qstat
);

    blp_pkg::run_t               slot_reg [blp_pkg::QUEUE_DEPTH];
    logic [blp_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [blp_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [blp_pkg::QCNT_W-1:0]  count_reg,  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign qstat.full  = (count_reg == blp_pkg::QCNT_W'(blp_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_run     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == blp_pkg::QPTR_W'(blp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + blp_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == blp_pkg::QPTR_W'(blp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + blp_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + blp_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - blp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/blp_back.sv =====
// ----------------------------------------------------------------------------
// blp_back: result serializer
// Takes run entries from the queue and, unless evt stalls, sends their results
// one per cycle, presses in button order, then heartbeat, then lamp write.
// ----------------------------------------------------------------------------
module blp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  blp_pkg::queue_status_t qstat,
    input  blp_pkg::run_t          pop_run,
    output logic                   pop,
    blp_evt_if.source              evt
);

    blp_pkg::run_t                  cur_reg, cur_next;
    logic                           cur_valid_reg, cur_valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic [blp_pkg::KIND_W-1:0]     kind_reg,   kind_next;
    logic [blp_pkg::BTN_NUM_W-1:0]  button_reg, button_next;
    logic [blp_pkg::PIXEL_W-1:0]    pixel_reg,  pixel_next;
    logic [blp_pkg::COLOR_W-1:0]    color_reg,  color_next;
    logic                           last_reg,   last_next;

    logic                           out_free;
    logic                           emit;
    blp_pkg::run_t                  rest;
    logic [blp_pkg::BTN_NUM_W-1:0]  low_btn;
    logic                           done;

    assign out_free = !out_valid_reg || evt.ready;
    assign emit     = cur_valid_reg && out_free;

    // Lowest pending press.
    always_comb
    begin
        low_btn = '0;
        for (int i = blp_pkg::BUTTONS - 1; i >= 0; i--)
        begin
            if (cur_reg.press[i])
            begin
                low_btn = blp_pkg::BTN_NUM_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        rest        = cur_reg;
        kind_next   = kind_reg;
        button_next = button_reg;
        pixel_next  = pixel_reg;
        color_next  = color_reg;
        priority if (|cur_reg.press)
        begin
            kind_next   = blp_pkg::EVT_PRESS;
            button_next = low_btn;
            pixel_next  = '0;
            color_next  = '0;
            for (int i = 0; i < blp_pkg::BUTTONS; i++)
            begin
                if (low_btn == blp_pkg::BTN_NUM_W'(i + 1))
                begin
                    rest.press[i] = 1'b0;
                end
            end
        end
        else if (cur_reg.heartbeat)
        begin
            kind_next      = blp_pkg::EVT_HEARTBEAT;
            button_next    = '0;
            pixel_next     = '0;
            color_next     = '0;
            rest.heartbeat = 1'b0;
        end
        else
        begin
            kind_next   = blp_pkg::EVT_LAMP;
            button_next = '0;
            pixel_next  = cur_reg.first_pixel;
            color_next  = cur_reg.pixel_color;
            rest.lamp   = 1'b0;
        end
        done      = !(|rest.press) && !rest.heartbeat && !rest.lamp;
        last_next = done;
    end

    // A new entry is taken when nothing is held or the held one finishes now.
    assign pop = !qstat.empty && (!cur_valid_reg || (emit && done));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_next       = pop_run;
            cur_valid_next = 1'b1;
        end
        else if (emit)
        begin
            cur_next       = rest;
            cur_valid_next = !done;
        end
        out_valid_next = emit ? 1'b1 : (out_valid_reg && !evt.ready);
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            kind_reg   <= kind_next;
            button_reg <= button_next;
            pixel_reg  <= pixel_next;
            color_reg  <= color_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.event_kind    = kind_reg;
    assign evt.button_number = button_reg;
    assign evt.first_pixel   = pixel_reg;
    assign evt.pixel_color   = color_reg;
    assign evt.last_of_run   = last_reg;

endmodule

// ===== rtl/debounced_button_lock_panel.sv =====
// ----------------------------------------------------------------------------
// debounced_button_lock_panel: six-button debouncer with press lockout
// Debounces active-low buttons, reports each settled press once until its
// lamp is set, emits heartbeats and turns lamp commands into pixel writes.
//
//   channel  role    handshake      carries
//   cmd      sink    valid/ready    tick sample or lamp command
//   evt      source  valid/ready    press, heartbeat or lamp write event
//   cfg_*    write   cfg_we only    debounce and heartbeat intervals
//
// The front takes one input transfer per cycle while the two-entry run queue
// has room; all state updates for that item finish in the same cycle.
// The back sets the sustained rate: it sends one result transfer per cycle
// unless evt stalls it, and holds each item until its results, up to 7, are out.
// Reset clears the control and debounce state at once; there is no clearing pass.
// A stalled result channel fills the queue, and then cmd.ready drops.
// ----------------------------------------------------------------------------
module debounced_button_lock_panel (
    input  logic                            clk,
    input  logic                            rst_n,
    blp_cmd_if.sink                         cmd,
    blp_evt_if.source                       evt,
    input  logic                            cfg_we,
    input  logic [blp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blp_pkg::CFG_W-1:0]       cfg_data
);

    // Configuration registers; writes to unknown indexes are dropped.
    blp_pkg::cfg_t          cfg_reg;

    // Front-to-queue and queue-to-back connections.
    logic                   push;
    blp_pkg::run_t          push_run;
    logic                   pop;
    blp_pkg::run_t          pop_run;
    blp_pkg::queue_status_t qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks  <= blp_pkg::DEBOUNCE_RESET;
            cfg_reg.heartbeat_ticks <= blp_pkg::HEARTBEAT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == blp_pkg::CFG_DEBOUNCE)
            begin
                cfg_reg.debounce_ticks <= cfg_data;
            end
            else if (cfg_index == blp_pkg::CFG_HEARTBEAT)
            begin
                cfg_reg.heartbeat_ticks <= cfg_data;
            end
        end
    end

    // The front classifies each item and records the results it causes.
    blp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .qstat    (qstat),
        .push     (push),
        .push_run (push_run)
    );

    // The queue lets the front keep taking items while results drain.
    blp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .pop_run  (pop_run),
        .qstat    (qstat)
    );

    // The back turns each run entry into result transfers, presses in button order first.
    blp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .pop_run (pop_run),
        .pop     (pop),
        .evt     (evt)
    );

endmodule

// ===== tb/debounced_button_lock_panel_checker.sv =====
// ----------------------------------------------------------------------------
// debounced_button_lock_panel_checker: event predictor and scoreboard
// Watches the command, result and register ports of the panel, predicts
// every event from its own copy of the debounce, lock and heartbeat state,
// and compares each result transfer field by field with the oldest one due.
// ----------------------------------------------------------------------------
module debounced_button_lock_panel_checker
    import blp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    blp_cmd_if                   cmd,
    blp_evt_if                   evt,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   failures,
    output int                   outstanding,
    output int                   events_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BTN_IDX_W = $clog2(BUTTONS);

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BTN_NUM_W-1:0] button;
        logic [PIXEL_W-1:0]   pixel;
        logic [COLOR_W-1:0]   color;
        logic                 last_of_run;
    } panel_event_t;

    logic [CFG_W-1:0]   debounce_limit;
    logic [CFG_W-1:0]   beat_limit;
    logic [BUTTONS-1:0] raw_last;
    logic [BUTTONS-1:0] settled;
    logic [BUTTONS-1:0] locked;
    logic [AGE_W-1:0]   hold_age [BUTTONS];
    logic [AGE_W-1:0]   beat_age;
    panel_event_t       due_events [$];
    int                 run_start;

    function automatic logic [COLOR_W-1:0] lamp_rgb(input logic [COLOR_CODE_W-1:0] code);
        logic [COLOR_W-1:0] rgb;
        rgb = '0;
        case (code)
            COLOR_RED:    rgb = {FULL_ON, 16'd0};
            COLOR_GREEN:  rgb = {8'd0, FULL_ON, 8'd0};
            COLOR_BLUE:   rgb = {16'd0, FULL_ON};
            COLOR_YELLOW: rgb = {FULL_ON, FULL_ON, 8'd0};
            default:      rgb = '0;
        endcase
        return rgb;
    endfunction

    function automatic void queue_event(input logic [KIND_W-1:0] kind,
                                        input logic [BTN_NUM_W-1:0] button,
                                        input logic [PIXEL_W-1:0] pixel,
                                        input logic [COLOR_W-1:0] color);
        panel_event_t ev;
        ev.kind        = kind;
        ev.button      = button;
        ev.pixel       = pixel;
        ev.color       = color;
        ev.last_of_run = 1'b0;
        due_events.push_back(ev);
    endfunction

    // Buttons are handled in index order, then the heartbeat.
    task automatic predict_tick(input logic [LEVEL_W-1:0] levels);
        logic level;
        for (int b = 0; b < BUTTONS; b++)
        begin
            level = levels[b];
            if (level != raw_last[b])
                hold_age[b] = '0;
            else if (hold_age[b] != AGE_MAX)
                hold_age[b] = hold_age[b] + AGE_W'(1);
            if (hold_age[b] > debounce_limit && level != settled[b])
            begin
                settled[b] = level;
                if (!level && !locked[b])
                begin
                    queue_event(EVT_PRESS, BTN_NUM_W'(b + 1), '0, '0);
                    locked[b] = 1'b1;
                end
            end
            raw_last[b] = level;
        end
        if (beat_age != AGE_MAX)
            beat_age = beat_age + AGE_W'(1);
        if (beat_age > beat_limit)
        begin
            beat_age = '0;
            queue_event(EVT_HEARTBEAT, '0, '0, '0);
        end
    endtask

    task automatic predict_lamp(input logic unit, input logic [LAMP_W-1:0] lamp,
                                input logic [COLOR_CODE_W-1:0] code);
        if (unit && lamp >= LAMP_W'(1) && lamp <= LAMP_W'(BUTTONS))
        begin
            queue_event(EVT_LAMP, '0, PIXEL_W'((lamp - 1) * PIXELS_PER_LAMP), lamp_rgb(code));
            locked[BTN_IDX_W'(lamp - LAMP_W'(1))] = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_event();
        panel_event_t want;
        if (due_events.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected transfer, expected none, actual kind %0d button %0d",
                     $time, evt.event_kind, evt.button_number);
            return;
        end
        want = due_events.pop_front();
        events_checked++;
        check_field("event_kind", want.kind, evt.event_kind);
        check_field("button_number", want.button, evt.button_number);
        check_field("first_pixel", want.pixel, evt.first_pixel);
        check_field("pixel_color", want.color, evt.pixel_color);
        check_field("last_of_run", want.last_of_run, evt.last_of_run);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit = DEBOUNCE_RESET;
            beat_limit     = HEARTBEAT_RESET;
            raw_last       = '1;
            settled        = '1;
            locked         = '0;
            beat_age       = '0;
            for (int b = 0; b < BUTTONS; b++)
                hold_age[b] = '0;
            due_events.delete();
            failures       = 0;
            outstanding    = 0;
            events_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEBOUNCE)
                    debounce_limit = cfg_data;
                else if (cfg_index == CFG_HEARTBEAT)
                    beat_limit = cfg_data;
            end
            if (cmd.valid && cmd.ready)
            begin
                run_start = due_events.size();
                if (cmd.command == CMD_TICK)
                    predict_tick(cmd.button_levels);
                else
                    predict_lamp(cmd.for_this_unit, cmd.lamp_number, cmd.color_code);
                if (due_events.size() > run_start)
                    due_events[due_events.size() - 1].last_of_run = 1'b1;
            end
            if (evt.valid && evt.ready)
                compare_event();
            outstanding = due_events.size();
        end
    end

endmodule

// ===== tb/debounced_button_lock_panel_tb.sv =====
// ----------------------------------------------------------------------------
// debounced_button_lock_panel_tb: top of the button lock panel testbench
// Drives tick samples, lamp commands and register writes into the panel,
// stalls both channels at random, and leaves prediction and comparison to
// the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module debounced_button_lock_panel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blp_pkg::*;

    // Register indexes past the two real registers; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int MAX_WAIT      = 18;
    localparam int PICK_W        = $clog2(LEVEL_W);
    // The checker's queue empties only once the back has sent every result;
    // this is a margin before touching registers.
    localparam int SETTLE_CYCLES = 24;
    // Worst case per item is a full sender gap plus seven results that each
    // wait out a full-length stall; 400 items of that is well under 1 ms.
    localparam int RUN_LIMIT_NS  = 4_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int failures;
    int outstanding;
    int events_checked;
    int ticks_sent;
    int lamps_sent;
    int settings_used;

    // While a side is calm it takes no idle cycles at all.
    bit src_calm;
    bit sink_calm;

    // Level pattern the buttons are currently being held at.
    logic [LEVEL_W-1:0] held;

    blp_cmd_if cmd_ch ();
    blp_evt_if evt_ch ();

    debounced_button_lock_panel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .evt       (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    debounced_button_lock_panel_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .evt            (evt_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .failures       (failures),
        .outstanding    (outstanding),
        .events_checked (events_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a result.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run stopped by the time limit.");
        $display("== FAIL ==");
        $finish;
    end

    // Draws the idle cycles before the next transfer. Now and then a side
    // switches between calm and busy, so long stretches without gaps appear.
    task automatic pick_wait(inout bit calm, output int cycles);
        if ($urandom_range(0, 24) == 0)
            calm = !calm;
        cycles = calm ? 0 : $urandom_range(0, MAX_WAIT);
    endtask

    // Offers one item and returns at the edge where it is transferred. Valid
    // is only lowered when a gap was drawn, so back-to-back items keep it high.
    task automatic send_item(input logic command, input logic [LEVEL_W-1:0] levels,
                             input logic unit, input logic [LAMP_W-1:0] lamp,
                             input logic [COLOR_CODE_W-1:0] color);
        int gap;
        pick_wait(src_calm, gap);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= command;
        cmd_ch.button_levels <= levels;
        cmd_ch.for_this_unit <= unit;
        cmd_ch.lamp_number   <= lamp;
        cmd_ch.color_code    <= color;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (command == CMD_TICK)
            ticks_sent++;
        else
            lamps_sent++;
    endtask

    // A tick ignores the lamp fields, so they carry random values.
    task automatic send_tick(input logic [LEVEL_W-1:0] levels);
        send_item(CMD_TICK, levels, 1'($urandom_range(0, 1)), LAMP_W'($urandom_range(0, 255)),
                  COLOR_CODE_W'($urandom_range(0, 7)));
    endtask

    // A lamp command ignores the button levels, so they carry random values.
    task automatic send_lamp(input logic unit, input logic [LAMP_W-1:0] lamp,
                             input logic [COLOR_CODE_W-1:0] color);
        send_item(CMD_LAMP, LEVEL_W'($urandom_range(0, 63)), unit, lamp, color);
    endtask

    // Writes both registers back to back, then a write to an unused index
    // that the block must ignore. Write enable drops only after the last one.
    task automatic set_limits(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] beat);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= debounce;
        @(posedge clk);
        cfg_index <= CFG_HEARTBEAT;
        cfg_data  <= beat;
        @(posedge clk);
        cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Stops offering items and waits until every predicted event has been
    // transferred, then lets the back run dry before registers may change.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random traffic. Buttons are mostly held steady long enough to settle,
    // with the occasional one-tick bounce, and lamp commands come in often
    // enough to unlock buttons so that they can be reported again. Lamp
    // commands that the block must ignore are mixed in and counted as well.
    task automatic random_phase(input int count);
        int made;
        int roll;
        logic [PICK_W-1:0] pick;
        made = 0;
        while (made < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_lamp(1'b1, LAMP_W'($urandom_range(1, BUTTONS)),
                              COLOR_CODE_W'($urandom_range(0, 7)));
                    made++;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: send_lamp(1'b0, LAMP_W'($urandom_range(0, 255)),
                                     COLOR_CODE_W'($urandom_range(0, 7)));
                        1: send_lamp(1'b1, 8'd0, COLOR_CODE_W'($urandom_range(0, 7)));
                        default: send_lamp(1'b1, LAMP_W'($urandom_range(BUTTONS + 1, 255)),
                                           COLOR_CODE_W'($urandom_range(0, 7)));
                    endcase
                    made++;
                end
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    pick = PICK_W'($urandom_range(0, BUTTONS - 1));
                    held[pick] = !held[pick];
                end
                else if (roll < 14)
                begin
                    held = LEVEL_W'($urandom_range(0, 63));
                end
                if (roll >= 14 && roll < 24)
                    send_tick(held ^ LEVEL_W'($urandom_range(1, 63)));
                else
                    send_tick(held);
                made++;
            end
        end
    endtask

    // Result side: every result gets its own drawn stall before ready rises.
    initial
    begin
        int gap;
        evt_ch.ready = 1'b0;
        sink_calm    = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pick_wait(sink_calm, gap);
            if (gap > 0)
            begin
                evt_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            evt_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!evt_ch.valid);
        end
    end

    // Stimulus: reset, a directed opening, then random phases under several
    // register settings, and finally the verdict.
    initial
    begin
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_TICK;
        cmd_ch.button_levels = '1;
        cmd_ch.for_this_unit = 1'b0;
        cmd_ch.lamp_number   = '0;
        cmd_ch.color_code    = '0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_DEBOUNCE;
        cfg_data             = '0;
        rst_n                = 1'b0;
        held                 = '1;
        src_calm             = 1'b0;
        ticks_sent           = 0;
        lamps_sent           = 0;
        settings_used        = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With both limits at zero a level settles on its second tick and
        // every tick produces a heartbeat.
        set_limits(16'd0, 16'd0);

        // All six settle low together: six presses and a heartbeat in one run.
        send_tick(6'h00);
        send_tick(6'h00);
        // Release, then press again: every button is still locked, so only
        // heartbeats come out.
        send_tick(6'h3F);
        send_tick(6'h3F);
        send_tick(6'h00);
        send_tick(6'h00);

        // One lamp of each color, two unknown color codes that must turn their
        // lamps off, and every lamp so that all buttons unlock.
        send_lamp(1'b1, 8'd1, COLOR_RED);
        send_lamp(1'b1, 8'd2, COLOR_GREEN);
        send_lamp(1'b1, 8'd3, COLOR_BLUE);
        send_lamp(1'b1, 8'd4, COLOR_YELLOW);
        send_lamp(1'b1, 8'd5, 3'd0);
        send_lamp(1'b1, 8'd6, 3'd7);
        // Lamp numbers out of range and a command for another unit: no result
        // and no unlock.
        send_lamp(1'b1, 8'd0, COLOR_RED);
        send_lamp(1'b1, 8'd7, COLOR_GREEN);
        send_lamp(1'b1, 8'd255, 3'd5);
        send_lamp(1'b0, 8'd1, 3'd6);

        // Release everything, then press alternating halves; the lamp writes
        // above unlocked all buttons, so each settled press is reported.
        send_tick(6'h3F);
        send_tick(6'h3F);
        send_tick(6'h2A);
        send_tick(6'h2A);
        send_tick(6'h15);
        send_tick(6'h15);

        settle();
        set_limits(16'd1, 16'd4);
        random_phase(80);

        settle();
        set_limits(16'd3, 16'd9);
        random_phase(80);

        // Heartbeat at its top value never fires; presses still do.
        settle();
        set_limits(16'd0, 16'hFFFF);
        random_phase(50);

        // Both at the top: nothing ever settles, only lamp writes appear.
        settle();
        set_limits(16'hFFFF, 16'hFFFF);
        random_phase(30);

        settle();
        set_limits(16'd2, 16'd0);
        random_phase(60);

        settle();
        set_limits(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 30)));
        random_phase(80);

        settle();

        $display("Sent %0d button ticks and %0d lamp commands under %0d register settings.",
                 ticks_sent, lamps_sent, settings_used);
        $display("Compared %0d result transfers field by field, %0d mismatches.",
                 events_checked, failures);
        if (failures == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/blp_pkg.sv
rtl/blp_cmd_if.sv
rtl/blp_evt_if.sv
rtl/blp_front.sv
rtl/blp_queue.sv
rtl/blp_back.sv
rtl/debounced_button_lock_panel.sv
tb/debounced_button_lock_panel_checker.sv
tb/debounced_button_lock_panel_tb.sv
